// ===== design/pid_pkg.sv =====
`default_nettype none

package pid_pkg;

   localparam int GAIN_W  = 32;
   localparam int ALPHA_W = 16;
   localparam int VAL_W   = 24;
   localparam int ERR_W   = 25;
   localparam int SUM_W   = 40;
   localparam int DER_W   = 48;
   localparam int DRV_W   = 18;
   localparam int PROD_W  = 73;
   localparam int TERM_W  = 52;
   localparam int U_W     = 54;
   localparam int FRAC_W  = 16;
   localparam int IDX_W   = 3;
   localparam int DATA_W  = 32;

   localparam logic LOOP_MANUAL = 1'b0;
   localparam logic LOOP_AUTO   = 1'b1;

   localparam logic signed [TERM_W-1:0] TERM_MAX  = 52'sh4_0000_0000_0000;
   localparam logic signed [TERM_W-1:0] TERM_MIN  = -TERM_MAX;
   localparam logic signed [SUM_W-1:0]  SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0]  SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic signed [DER_W-1:0]  DER_MAX   = {1'b0, {(DER_W-1){1'b1}}};
   localparam logic signed [DER_W-1:0]  DER_MIN   = {1'b1, {(DER_W-1){1'b0}}};
   localparam logic signed [DRV_W-1:0]  DRIVE_MAX = 18'sd65536;
   localparam logic signed [DRV_W-1:0]  DRIVE_MIN = -18'sd65536;
   localparam logic signed [VAL_W-1:0]  SETPOINT_RESET = 24'sd65536;

   typedef enum logic [IDX_W-1:0] {
      REG_KP_GAIN,
      REG_KI_STEP,
      REG_KD_STEP,
      REG_FILTER_ALPHA,
      REG_SETPOINT,
      REG_LOOP_MODE
   } pid_reg_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  kp_gain;
      logic [GAIN_W-1:0]  ki_step;
      logic [GAIN_W-1:0]  kd_step;
      logic [ALPHA_W-1:0] filter_alpha;
      logic [VAL_W-1:0]   setpoint;
      logic               loop_mode;
   } pid_cfg_type;

   typedef struct packed {
      logic [DRV_W-1:0] drive;
      logic             clamped;
   } pid_result_type;

   // floor(product / 2^16), limited to +/-2^50
   function automatic logic signed [TERM_W-1:0] q16_term(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-FRAC_W-1:0] q;
      q = p[PROD_W-1:FRAC_W];
      if (q > TERM_MAX) begin
         return TERM_MAX;
      end else if (q < TERM_MIN) begin
         return TERM_MIN;
      end
      return $signed(q[TERM_W-1:0]);
   endfunction

   function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
      if (v > SUM_MAX) begin
         return SUM_MAX;
      end else if (v < SUM_MIN) begin
         return SUM_MIN;
      end
      return $signed(v[SUM_W-1:0]);
   endfunction

   function automatic logic signed [DER_W-1:0] sat_der(input logic signed [TERM_W:0] v);
      if (v > DER_MAX) begin
         return DER_MAX;
      end else if (v < DER_MIN) begin
         return DER_MIN;
      end
      return $signed(v[DER_W-1:0]);
   endfunction

endpackage

`default_nettype wire

// ===== design/pid_csr.sv =====
`default_nettype none

module pid_csr
   import pid_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wen,
   input  wire logic [IDX_W-1:0]  csr_index,
   input  wire logic [DATA_W-1:0] csr_wdata,
   output pid_cfg_type            cfg,
   output logic                   clear_state
);

   pid_cfg_type cfg_ff;
   pid_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            REG_KP_GAIN:      cfg_in.kp_gain      = csr_wdata;
            REG_KI_STEP:      cfg_in.ki_step      = csr_wdata;
            REG_KD_STEP:      cfg_in.kd_step      = csr_wdata;
            REG_FILTER_ALPHA: cfg_in.filter_alpha = csr_wdata[ALPHA_W-1:0];
            REG_SETPOINT:     cfg_in.setpoint     = csr_wdata[VAL_W-1:0];
            REG_LOOP_MODE:    cfg_in.loop_mode    = csr_wdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp_gain      <= '0;
         cfg_ff.ki_step      <= '0;
         cfg_ff.kd_step      <= '0;
         cfg_ff.filter_alpha <= '0;
         cfg_ff.setpoint     <= SETPOINT_RESET;
         cfg_ff.loop_mode    <= LOOP_MANUAL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg         = cfg_ff;
   assign clear_state = csr_wen && (csr_index == REG_LOOP_MODE) && (csr_wdata[0] == LOOP_MANUAL);

endmodule

`default_nettype wire

// ===== design/pid_core.sv =====
`default_nettype none

module pid_core
   import pid_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pid_cfg_type       cfg,
   input  wire logic              clear_state,
   input  wire logic              step,
   input  wire logic [VAL_W-1:0]  measured,
   output pid_result_type         result
);

   logic signed [SUM_W-1:0]  error_sum_ff, error_sum_in;
   logic signed [ERR_W-1:0]  prev_error_ff, prev_error_in;
   logic signed [VAL_W-1:0]  prev_measured_ff, prev_measured_in;
   logic signed [DER_W-1:0]  prev_deriv_ff, prev_deriv_in;

   logic signed [VAL_W-1:0]  m;
   logic signed [VAL_W-1:0]  sp;
   logic signed [ERR_W-1:0]  e;
   logic signed [ERR_W-1:0]  diff;
   logic signed [SUM_W-1:0]  sum_new;
   logic signed [57:0]       p_kp;
   logic signed [PROD_W-1:0] p_ki;
   logic signed [57:0]       p_kd;
   logic signed [64:0]       p_al;
   logic signed [TERM_W-1:0] t_kp, t_ki, t_kd, t_al;
   logic signed [DER_W-1:0]  d;
   logic signed [U_W-1:0]    u;
   logic                     hit;

   assign m       = $signed(measured);
   assign sp      = $signed(cfg.setpoint);
   assign e       = ERR_W'(sp) - ERR_W'(m);
   assign diff    = ERR_W'(m) - ERR_W'(prev_measured_ff);
   assign sum_new = sat_sum((SUM_W+1)'(error_sum_ff) + (SUM_W+1)'(prev_error_ff));

   assign p_kp = $signed({1'b0, cfg.kp_gain}) * e;
   assign p_ki = $signed({1'b0, cfg.ki_step}) * sum_new;
   assign p_kd = $signed({1'b0, cfg.kd_step}) * diff;
   assign p_al = $signed({1'b0, cfg.filter_alpha}) * prev_deriv_ff;

   assign t_kp = q16_term(PROD_W'(p_kp));
   assign t_ki = q16_term(p_ki);
   assign t_kd = q16_term(PROD_W'(p_kd));
   assign t_al = q16_term(PROD_W'(p_al));

   assign d   = sat_der((TERM_W+1)'(t_kd) + (TERM_W+1)'(t_al));
   assign u   = U_W'(t_kp) + U_W'(t_ki) - U_W'(d);
   assign hit = (u > DRIVE_MAX) || (u < DRIVE_MIN);

   always_comb begin
      if (u > DRIVE_MAX) begin
         result.drive = DRIVE_MAX;
      end else if (u < DRIVE_MIN) begin
         result.drive = DRIVE_MIN;
      end else begin
         result.drive = u[DRV_W-1:0];
      end
      result.clamped = hit;
   end

   always_comb begin
      error_sum_in     = error_sum_ff;
      prev_error_in    = prev_error_ff;
      prev_measured_in = prev_measured_ff;
      prev_deriv_in    = prev_deriv_ff;
      if (clear_state) begin
         error_sum_in     = '0;
         prev_error_in    = '0;
         prev_measured_in = '0;
      end else if (step) begin
         prev_error_in    = e;
         prev_measured_in = m;
         if (cfg.loop_mode == LOOP_AUTO) begin
            error_sum_in  = hit ? error_sum_ff : sum_new;
            prev_deriv_in = d;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff     <= '0;
         prev_error_ff    <= '0;
         prev_measured_ff <= '0;
         prev_deriv_ff    <= '0;
      end else begin
         error_sum_ff     <= error_sum_in;
         prev_error_ff    <= prev_error_in;
         prev_measured_ff <= prev_measured_in;
         prev_deriv_ff    <= prev_deriv_in;
      end
   end

`ifndef SYNTHESIS
   a_windup_hold: assert property (@(posedge clock) disable iff (reset)
      step && (cfg.loop_mode == LOOP_AUTO) && hit && !clear_state
      |=> error_sum_ff == $past(error_sum_ff))
      else $error("integral moved on a clamped sample");

   a_manual_clear: assert property (@(posedge clock) disable iff (reset)
      clear_state |=> (error_sum_ff == '0) && (prev_error_ff == '0) && (prev_measured_ff == '0))
      else $error("manual write did not clear state");

   a_manual_deriv: assert property (@(posedge clock) disable iff (reset)
      (cfg.loop_mode == LOOP_MANUAL) |=> $stable(prev_deriv_ff))
      else $error("derivative state moved in manual mode");
`endif

endmodule

`default_nettype wire

// ===== design/pid_filtered_derivative_antiwindup.sv =====
`default_nettype none

// PID controller with a first-order filtered derivative on the measurement and
// integral anti-windup. Each request carries one Q8.16 measurement; in automatic
// mode it yields one Q2.16 drive clamped to +/-1.0 with a clamp flag, in manual
// mode it only tracks the previous error and measurement and yields nothing.
// A request goes through an input register, one pass of multiply, saturate and
// sum logic that also updates the loop state, and a result register. The
// throughput is one request per cycle while the result is not stalled, set by the
// single-pass state update (integral, previous derivative) that each sample needs
// before the next. In automatic mode a stalled result holds the request in the
// input register, and req_stall stays high until the result is taken.
// Writing loop_mode 0 clears the integral, previous error and measurement.
module pid_filtered_derivative_antiwindup
   import pid_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_wen,
   input  wire logic [IDX_W-1:0]         csr_index,
   input  wire logic [DATA_W-1:0]        csr_wdata,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic signed [VAL_W-1:0]  req_measured,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [DRV_W-1:0]       rsp_drive,
   output logic                          rsp_clamped
);

   pid_cfg_type    cfg;
   pid_result_type result;
   logic           clear_state;

   logic             in_valid_ff, in_valid_in;
   logic [VAL_W-1:0] in_measured_ff, in_measured_in;
   logic             rsp_valid_ff, rsp_valid_in;
   pid_result_type   rsp_ff, rsp_in;
   logic             advance;
   logic             accept;
   logic             rsp_load;
   logic             auto_mode;

   pid_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cfg         (cfg),
      .clear_state (clear_state)
   );

   pid_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .clear_state (clear_state),
      .step        (advance),
      .measured    (in_measured_ff),
      .result      (result)
   );

   assign auto_mode = (cfg.loop_mode == LOOP_AUTO);
   assign advance   = in_valid_ff && (!auto_mode || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign rsp_load  = advance && auto_mode;

   assign in_valid_in    = accept || (in_valid_ff && !advance);
   assign in_measured_in = accept ? req_measured : in_measured_ff;
   assign rsp_valid_in   = rsp_load || (rsp_valid_ff && rsp_stall);
   assign rsp_in         = rsp_load ? result : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_measured_ff <= in_measured_in;
      rsp_ff         <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_drive   = $signed(rsp_ff.drive);
   assign rsp_clamped = rsp_ff.clamped;

`ifndef SYNTHESIS
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive <= DRIVE_MAX) && (rsp_drive >= DRIVE_MIN))
      else $error("drive outside +/-1.0");

   a_clamp_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clamped |-> (rsp_drive == DRIVE_MAX) || (rsp_drive == DRIVE_MIN))
      else $error("clamp flag without drive at a limit");

   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_measured_ff))
      else $error("pending request lost while stalled");
`endif

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pid_pkg::*;

   localparam logic [IDX_W-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [IDX_W-1:0] REG_SPARE_7 = 3'd7;
   localparam logic signed [63:0] TERM_LIMIT = 64'sd1 <<< 50;
   localparam logic signed [63:0] FULL_SCALE = 64'sd65536;
   localparam int SETTLE_CYCLES = 6;
   localparam int SAMPLES_PER_SEGMENT = 30;

   typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [IDX_W-1:0]  index;
      logic [DATA_W-1:0] value;
      logic              typed;
      pid_result_type    result;
   } step_row_type;

   localparam int NUM_ROWS = 32;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_wen = 1'b0;
   logic [IDX_W-1:0]         csr_index = '0;
   logic [DATA_W-1:0]        csr_wdata = '0;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [VAL_W-1:0]  req_measured = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DRV_W-1:0]  rsp_drive;
   logic                     rsp_clamped;

   logic [GAIN_W-1:0]        kp_now = '0;
   logic [GAIN_W-1:0]        ki_now = '0;
   logic [GAIN_W-1:0]        kd_now = '0;
   logic [ALPHA_W-1:0]       alpha_now = '0;
   logic signed [VAL_W-1:0]  target_setpoint = SETPOINT_RESET;
   logic                     loop_mode_now = LOOP_MANUAL;
   logic signed [SUM_W-1:0]  integral = '0;
   logic signed [ERR_W-1:0]  last_error = '0;
   logic signed [VAL_W-1:0]  last_measured = '0;
   logic signed [DER_W-1:0]  last_deriv = '0;

   pid_result_type           expected_drive[$];
   int                       failures = 0;
   int                       checked = 0;
   int                       clamp_count = 0;
   int                       sample_count = 0;
   int                       write_count = 0;
   int                       sender_idle_pct = 0;
   int                       receiver_stall_pct = 0;
   int                       idle_plan[4] = '{0, 64, 0, 15};
   int                       stall_plan[4] = '{0, 0, 64, 15};

   step_row_type directed_rows[NUM_ROWS] = '{
      '{ROW_SAMPLE, REG_KP_GAIN,      32'h0000_0000, 1'b0, '{18'sd0, 1'b0}},
      '{ROW_WRITE,  REG_LOOP_MODE,    32'h0000_0001, 1'b0, '{18'sd0, 1'b0}},
      '{ROW_SAMPLE, REG_KP_GAIN,      32'h0000_0000, 1'b1, '{18'sd0, 1'b0}},
      '{ROW_WRITE,  REG_KP_GAIN,      32'h0001_0000, 1'b0, '{18'sd0, 1'b0}},
      '{ROW_SAMPLE, REG_KP_GAIN,      32'h0000_0000, 1'b1, '{18'sd65536, 1'b0}},
      '{ROW_SAMPLE, REG_KP_GAIN,      32'h00FF_FFFF, 1'b1, '{18'sd65536, 1'b1}},
      '{ROW_SAMPLE, REG_KP_GAIN,      32'h0002_0000, 1'b1, '{-18'sd65536, 1'b0}},
      '{ROW_SAMPLE, REG_KP_GAIN,      32'h0002_0001, 1'b1, '{-18'sd65536, 1'b1}},
      '{ROW_SAMPLE, REG_KP_GAIN,      32'h007F_FFFF, 1'b1, '{-18'sd65536, 1'b1}},
      '{ROW_SAMPLE, REG_KP_GAIN,      32'h0080_0000, 1'b1, '{18'sd65536, 1'b1}},
      '{ROW_WRITE,  REG_KP_GAIN,      32'hFFFF_FFFF, 1'b0, '{18'sd0, 1'b0}},
      '{ROW_SAMPLE, REG_KP_GAIN,      32'h0001_0000, 1'b1, '{18'sd0, 1'b0}},
      '{ROW_WRITE,  REG_KI_STEP,      32'h0000_0800, 1'b0, '{18'sd0, 1'b0}},
      '{ROW_WRITE,  REG_KD_STEP,      32'hFFFF_FFFF, 1'b0, '{18'sd0, 1'b0}},
      '{ROW_WRITE,  REG_FILTER_ALPHA, 32'hFFFF_FFFF, 1'b0, '{18'sd0, 1'b0}},
      '{ROW_WRITE,  REG_SETPOINT,     32'hFF80_0000, 1'b0, '{18'sd0, 1'b0}},
      '{ROW_SAMPLE, REG_KP_GAIN,      32'h007F_FFFF, 1'b0, '{18'sd0, 1'b0}},
      '{ROW_SAMPLE, REG_KP_GAIN,      32'h0080_0000, 1'b0, '{18'sd0, 1'b0}},
      '{ROW_WRITE,  REG_SETPOINT,     32'h007F_FFFF, 1'b0, '{18'sd0, 1'b0}},
      '{ROW_WRITE,  REG_LOOP_MODE,    32'hFFFF_FFFE, 1'b0, '{18'sd0, 1'b0}},
      '{ROW_SAMPLE, REG_KP_GAIN,      32'h0012_3456, 1'b0, '{18'sd0, 1'b0}},
      '{ROW_WRITE,  REG_LOOP_MODE,    32'h0000_0000, 1'b0, '{18'sd0, 1'b0}},
      '{ROW_WRITE,  REG_SPARE_6,      32'hFFFF_FFFF, 1'b0, '{18'sd0, 1'b0}},
      '{ROW_WRITE,  REG_SPARE_7,      32'hFFFF_FFFF, 1'b0, '{18'sd0, 1'b0}},
      '{ROW_WRITE,  REG_LOOP_MODE,    32'h0000_0003, 1'b0, '{18'sd0, 1'b0}},
      '{ROW_SAMPLE, REG_KP_GAIN,      32'h0080_0000, 1'b0, '{18'sd0, 1'b0}},
      '{ROW_SAMPLE, REG_KP_GAIN,      32'h0000_0000, 1'b0, '{18'sd0, 1'b0}},
      '{ROW_WRITE,  REG_KP_GAIN,      32'h0000_0000, 1'b0, '{18'sd0, 1'b0}},
      '{ROW_WRITE,  REG_KI_STEP,      32'h0000_0000, 1'b0, '{18'sd0, 1'b0}},
      '{ROW_WRITE,  REG_KD_STEP,      32'h0000_0000, 1'b0, '{18'sd0, 1'b0}},
      '{ROW_WRITE,  REG_FILTER_ALPHA, 32'h0000_0000, 1'b0, '{18'sd0, 1'b0}},
      '{ROW_SAMPLE, REG_KP_GAIN,      32'h0040_0000, 1'b1, '{18'sd0, 1'b0}}
   };

   pid_filtered_derivative_antiwindup DUT (
      .clock        (clock),
      .reset        (reset),
      .csr_wen      (csr_wen),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_measured (req_measured),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_drive    (rsp_drive),
      .rsp_clamped  (rsp_clamped)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   function automatic logic signed [63:0] saturate(input logic signed [63:0] v, input int bits);
      logic signed [63:0] top;
      top = (64'sd1 <<< (bits - 1)) - 64'sd1;
      if (v > top) return top;
      if (v < -top - 64'sd1) return -top - 64'sd1;
      return v;
   endfunction

   // floor(k * x / 2^16), held to +/-2^50
   function automatic logic signed [63:0] scaled_product(input logic [GAIN_W-1:0] k,
                                                         input logic signed [63:0] x);
      logic signed [127:0] wide_k;
      logic signed [127:0] wide_x;
      logic signed [127:0] p;
      wide_k = {96'd0, k};
      wide_x = x;
      p = (wide_k * wide_x) >>> FRAC_W;
      if (p > TERM_LIMIT) return TERM_LIMIT;
      if (p < -TERM_LIMIT) return -TERM_LIMIT;
      return p[63:0];
   endfunction

   function automatic bit predict_drive(input logic signed [VAL_W-1:0] m,
                                        output pid_result_type r);
      logic signed [63:0] err;
      logic signed [63:0] delta;
      logic signed [63:0] last_sum;
      logic signed [63:0] sum;
      logic signed [63:0] deriv;
      logic signed [63:0] u;
      r = '0;
      err = target_setpoint - m;
      if (loop_mode_now == LOOP_MANUAL) begin
         last_measured = m;
         last_error = err[ERR_W-1:0];
         return 1'b0;
      end
      last_sum = integral;
      sum = saturate(last_sum + last_error, SUM_W);
      delta = m - last_measured;
      deriv = saturate(scaled_product(kd_now, delta)
                       + scaled_product({16'd0, alpha_now}, last_deriv), DER_W);
      u = scaled_product(kp_now, err) + scaled_product(ki_now, sum) - deriv;
      last_error = err[ERR_W-1:0];
      last_measured = m;
      last_deriv = deriv[DER_W-1:0];
      integral = sum[SUM_W-1:0];
      if (u > FULL_SCALE) begin
         r.drive = DRIVE_MAX;
         r.clamped = 1'b1;
         integral = last_sum[SUM_W-1:0];
      end else if (u < -FULL_SCALE) begin
         r.drive = DRIVE_MIN;
         r.clamped = 1'b1;
         integral = last_sum[SUM_W-1:0];
      end else begin
         r.drive = u[DRV_W-1:0];
      end
      return 1'b1;
   endfunction

   function automatic void apply_write(input logic [IDX_W-1:0] index,
                                       input logic [DATA_W-1:0] data);
      case (index)
         REG_KP_GAIN:      kp_now = data;
         REG_KI_STEP:      ki_now = data;
         REG_KD_STEP:      kd_now = data;
         REG_FILTER_ALPHA: alpha_now = data[ALPHA_W-1:0];
         REG_SETPOINT:     target_setpoint = data[VAL_W-1:0];
         REG_LOOP_MODE: begin
            loop_mode_now = data[0];
            if (data[0] == LOOP_MANUAL) begin
               integral = '0;
               last_error = '0;
               last_measured = '0;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_gain(input int unsigned typical);
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return $urandom();
         default: return $urandom_range(0, typical);
      endcase
   endfunction

   task automatic write_reg(input logic [IDX_W-1:0] index, input logic [DATA_W-1:0] data);
      csr_wen <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      apply_write(index, data);
      write_count++;
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_sample(input logic signed [VAL_W-1:0] m, input logic use_typed,
                              input pid_result_type typed);
      pid_result_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_measured <= m;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      sample_count++;
      if (predict_drive(m, predicted))
         expected_drive.push_back(use_typed ? typed : predicted);
   endtask

   // hold off until every drive is back and the pipeline is empty
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_drive.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_segment();
      logic signed [VAL_W-1:0] m;
      logic [DATA_W-1:0]       mode_word;
      pid_result_type          unused;
      unused = '0;
      settle();
      write_reg(REG_KP_GAIN, pick_gain(32'h0002_0000));
      write_reg(REG_KI_STEP, pick_gain(32'h0000_4000));
      write_reg(REG_KD_STEP, pick_gain(32'h0002_0000));
      write_reg(REG_FILTER_ALPHA, $urandom());
      if ($urandom_range(3) == 0)
         write_reg(REG_SETPOINT, $urandom());
      else
         write_reg(REG_SETPOINT, $urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
      if ($urandom_range(7) == 0)
         write_reg($urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7, $urandom());
      mode_word = $urandom() & ~32'd1;
      if ($urandom_range(99) < 85)
         mode_word = mode_word | {31'd0, LOOP_AUTO};
      write_reg(REG_LOOP_MODE, mode_word);
      for (int n = 0; n < SAMPLES_PER_SEGMENT; n++) begin
         case ($urandom_range(9))
            0:       m = VAL_W'($urandom());
            1:       m = $urandom_range(1) ? 24'h7F_FFFF : 24'h80_0000;
            default: m = target_setpoint + 24'($urandom_range(0, 32'h0002_0000)) - 24'h01_0000;
         endcase
         send_sample(m, 1'b0, unused);
      end
   endtask

   always @(posedge clock) begin
      pid_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_drive.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected drive %0d clamped %0b", rsp_drive, rsp_clamped);
         end else begin
            want = expected_drive.pop_front();
            checked++;
            if (rsp_clamped === 1'b1) clamp_count++;
            if (rsp_drive !== want.drive || rsp_clamped !== want.clamped) begin
               failures++;
               if (failures <= 10)
                  $display("drive mismatch: expected %0d clamped %0b, got %0d clamped %0b",
                           $signed(want.drive), want.clamped, rsp_drive, rsp_clamped);
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct = 15;
      receiver_stall_pct = 15;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            settle();
            write_reg(directed_rows[i].index, directed_rows[i].value);
         end else begin
            send_sample(directed_rows[i].value[VAL_W-1:0], directed_rows[i].typed,
                        directed_rows[i].result);
         end
      end

      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct = idle_plan[phase];
         receiver_stall_pct = stall_plan[phase];
         for (int seg = 0; seg < 4; seg++)
            random_segment();
      end

      settle();
      repeat (10) @(posedge clock);
      $display("Sent %0d samples and %0d register writes across four idle/stall mixes,",
               sample_count, write_count);
      $display("checked %0d drive values, %0d of them at a clamp limit.", checked, clamp_count);
      if (failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
design/pid_pkg.sv
design/pid_csr.sv
design/pid_core.sv
design/pid_filtered_derivative_antiwindup.sv
sim/testbench.sv
